@@ rtl/bblru_pkg.sv @@
`timescale 1ns / 1ps

package bblru_pkg;

   localparam int DEF_ENTRIES = 32;
   localparam int BYTES_W = 31;
   localparam int SIZE_W = 28;
   localparam int TIME_W = 32;
   localparam int COUNT_W = 6;
   localparam int EV_IDX_W = 5;
   localparam int EVICT_N_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTES_W-1:0] DEF_HIGH_WM = 31'd134217728;
   localparam logic [BYTES_W-1:0] DEF_LOW_WM = 31'd67108864;
   localparam logic [BYTES_W-1:0] BYTES_MAX = 31'h7FFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
   localparam logic [EVICT_N_W-1:0] MAX_EVICT = 5'd31;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_WM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_WM = 2'd1;

   typedef enum logic [1:0] {
      CMD_LOAD_DONE = 2'd0,
      CMD_USE = 2'd1,
      CMD_DROP = 2'd2,
      CMD_LOAD_FAILED = 2'd3
   } command_type;

   typedef enum logic {
      KIND_EVICT = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      command_type command;
      logic [4:0] entry_index;
      logic [SIZE_W-1:0] entry_bytes;
      logic pinned;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      kind_type kind;
      logic [EV_IDX_W-1:0] evicted_index;
      logic hit;
      logic needs_load;
      logic [BYTES_W-1:0] total_bytes;
      logic [COUNT_W-1:0] resident_count;
      logic last;
   } rsp_type;

endpackage

@@ rtl/byte_budget_lru_evictor.sv @@
`timescale 1ns / 1ps

// Byte-budget LRU evictor. A command item is taken when start is high and busy is low; every
// result is a one-cycle pulse on rsp_strobe that the receiver must take as it comes, the last
// result of an item has last set and busy is already low in that cycle. Use, drop, load-failed
// and out-of-range items give their status from the lookup state. A load that stays at or
// under the high watermark gives its status through the lookup, load-check and finish states.
// Above it, each victim search passes the scan, drain and decide states, the scan reading the
// size/time memory one entry per cycle from entry 1; a search without a victim ends the load,
// else the victim is evicted and the low watermark and eviction cap are checked again before
// another search or completion. Flags are flip-flops reset to fixed values, so no clearing pass;
// the configuration port is always ready and may be written only while busy is low.
module byte_budget_lru_evictor #(
   parameter int ENTRIES = bblru_pkg::DEF_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  bblru_pkg::req_type                  req_item,
   output logic                                rsp_strobe,
   output bblru_pkg::rsp_type                  rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bblru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bblru_pkg::BYTES_W-1:0]       csr_wdata
);
   import bblru_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_LOAD_CHECK,
      ST_EV_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_EV_DECIDE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   req_type req_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [BYTES_W-1:0] high_wm_ff;
   logic [BYTES_W-1:0] low_wm_ff;
   logic [ENTRIES-1:0] resident_ff;
   logic [ENTRIES-1:0] pinned_ff;
   logic [ENTRIES-1:0] loadable_ff;
   logic [ENTRIES-1:0] time_valid_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [EVICT_N_W-1:0] evict_n_ff;
   logic [IDX_W-1:0] scan_ff;
   logic pend_ff;
   logic [IDX_W-1:0] pend_idx_ff;
   logic found_ff;
   logic [IDX_W-1:0] best_ff;
   logic [TIME_W-1:0] best_age_ff;
   logic [SIZE_W-1:0] best_size_ff;
   logic rsp_strobe_ff;
   rsp_type rsp_ff;

   logic [SIZE_W-1:0] size_ram [ENTRIES];
   logic [TIME_W-1:0] time_ram [ENTRIES];
   logic [SIZE_W-1:0] size_rd_ff;
   logic [TIME_W-1:0] time_rd_ff;
   logic time_valid_rd_ff;

   logic [IDX_W-1:0] rd_addr;
   logic in_range;
   logic [SIZE_W-1:0] rel_size;
   logic [BYTES_W-1:0] rel_bytes;
   logic [COUNT_W-1:0] rel_count;
   logic [TIME_W-1:0] cand_time;
   logic [TIME_W-1:0] cand_age;
   logic better;
   logic [BYTES_W:0] load_sum;
   logic over_high;
   logic [BYTES_W-1:0] load_bytes;
   logic use_hit;
   logic size_we;
   logic time_we;

   function automatic rsp_type make_rsp(kind_type k, logic [EV_IDX_W-1:0] ev, logic h,
                                        logic n, logic [BYTES_W-1:0] b,
                                        logic [COUNT_W-1:0] c, logic l);
      rsp_type r;
      r.kind = k;
      r.evicted_index = ev;
      r.hit = h;
      r.needs_load = n;
      r.total_bytes = b;
      r.resident_count = c;
      r.last = l;
      return r;
   endfunction

   always_comb begin
      rd_addr = (state_ff == ST_SCAN) ? scan_ff : IDX_W'(req_item.entry_index);
      in_range = 32'(req_ff.entry_index) < ENTRIES;
      rel_size = (state_ff == ST_EV_DECIDE) ? best_size_ff : size_rd_ff;
      rel_bytes = (bytes_ff >= BYTES_W'(rel_size)) ? bytes_ff - BYTES_W'(rel_size) : '0;
      rel_count = (count_ff != '0) ? count_ff - 1'b1 : '0;
      cand_time = time_valid_rd_ff ? time_rd_ff : '0;
      cand_age = req_ff.now - cand_time;
      better = resident_ff[pend_idx_ff] && !pinned_ff[pend_idx_ff]
               && (!found_ff || cand_age > best_age_ff);
      load_sum = {1'b0, bytes_ff} + (BYTES_W + 1)'(req_ff.entry_bytes);
      over_high = load_sum > {1'b0, high_wm_ff};
      load_bytes = load_sum[BYTES_W] ? BYTES_MAX : load_sum[BYTES_W-1:0];
      use_hit = loadable_ff[idx_ff] && resident_ff[idx_ff];
      size_we = (state_ff == ST_FINISH);
      time_we = (state_ff == ST_LOOKUP) && in_range && (req_ff.command == CMD_USE) && use_hit;
   end

   always_ff @(posedge clock) begin
      size_rd_ff <= size_ram[rd_addr];
      time_rd_ff <= time_ram[rd_addr];
      time_valid_rd_ff <= time_valid_ff[rd_addr];
      if (size_we) begin
         size_ram[idx_ff] <= req_ff.entry_bytes;
      end
      if (time_we) begin
         time_ram[idx_ff] <= req_ff.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         high_wm_ff <= DEF_HIGH_WM;
         low_wm_ff <= DEF_LOW_WM;
         resident_ff <= '0;
         pinned_ff <= '0;
         loadable_ff <= '1;
         time_valid_ff <= '0;
         bytes_ff <= '0;
         count_ff <= '0;
         evict_n_ff <= '0;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         pend_ff <= 1'b0;

         if (csr_valid) begin
            case (csr_index)
               CSR_HIGH_WM: high_wm_ff <= csr_wdata;
               CSR_LOW_WM: low_wm_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (pend_ff && better) begin
            found_ff <= 1'b1;
            best_ff <= pend_idx_ff;
            best_age_ff <= cand_age;
            best_size_ff <= size_rd_ff;
         end

         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff <= req_item;
                  idx_ff <= IDX_W'(req_item.entry_index);
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               evict_n_ff <= '0;
               if (!in_range) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff <= make_rsp(KIND_STATUS, '0, 1'b0, 1'b0, bytes_ff, count_ff, 1'b1);
                  state_ff <= ST_IDLE;
               end else begin
                  case (req_ff.command)
                     CMD_LOAD_DONE: begin
                        if (resident_ff[idx_ff]) begin
                           resident_ff[idx_ff] <= 1'b0;
                           bytes_ff <= rel_bytes;
                           count_ff <= rel_count;
                        end
                        state_ff <= ST_LOAD_CHECK;
                     end
                     CMD_USE: begin
                        if (use_hit) begin
                           time_valid_ff[idx_ff] <= 1'b1;
                        end
                        rsp_strobe_ff <= 1'b1;
                        rsp_ff <= make_rsp(KIND_STATUS, '0, use_hit,
                                           loadable_ff[idx_ff] && !resident_ff[idx_ff],
                                           bytes_ff, count_ff, 1'b1);
                        state_ff <= ST_IDLE;
                     end
                     CMD_DROP: begin
                        rsp_strobe_ff <= 1'b1;
                        if (resident_ff[idx_ff]) begin
                           resident_ff[idx_ff] <= 1'b0;
                           bytes_ff <= rel_bytes;
                           count_ff <= rel_count;
                           rsp_ff <= make_rsp(KIND_STATUS, '0, 1'b0, 1'b0,
                                              rel_bytes, rel_count, 1'b1);
                        end else begin
                           rsp_ff <= make_rsp(KIND_STATUS, '0, 1'b0, 1'b0,
                                              bytes_ff, count_ff, 1'b1);
                        end
                        state_ff <= ST_IDLE;
                     end
                     default: begin
                        loadable_ff[idx_ff] <= 1'b0;
                        rsp_strobe_ff <= 1'b1;
                        rsp_ff <= make_rsp(KIND_STATUS, '0, 1'b0, 1'b0,
                                           bytes_ff, count_ff, 1'b1);
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_LOAD_CHECK: begin
               state_ff <= over_high ? ST_EV_CHECK : ST_FINISH;
            end
            ST_EV_CHECK: begin
               if (bytes_ff > low_wm_ff && evict_n_ff < MAX_EVICT) begin
                  scan_ff <= IDX_W'(1);
                  found_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SCAN: begin
               pend_ff <= 1'b1;
               pend_idx_ff <= scan_ff;
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_EV_DECIDE;
            end
            ST_EV_DECIDE: begin
               if (found_ff) begin
                  resident_ff[best_ff] <= 1'b0;
                  bytes_ff <= rel_bytes;
                  count_ff <= rel_count;
                  evict_n_ff <= evict_n_ff + 1'b1;
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff <= make_rsp(KIND_EVICT, EV_IDX_W'(best_ff), 1'b0, 1'b0,
                                     rel_bytes, rel_count, 1'b0);
                  state_ff <= ST_EV_CHECK;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               bytes_ff <= load_bytes;
               count_ff <= (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
               resident_ff[idx_ff] <= 1'b1;
               pinned_ff[idx_ff] <= req_ff.pinned;
               rsp_strobe_ff <= 1'b1;
               rsp_ff <= make_rsp(KIND_STATUS, '0, 1'b0, 1'b0, load_bytes,
                                  (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1,
                                  1'b1);
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |-> !busy)
      else $error("final result while still busy");

   a_never_entry0: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV_DECIDE) && found_ff |-> best_ff != '0)
      else $error("entry 0 chosen as victim");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_evict_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.kind == KIND_EVICT) |-> busy && (evict_n_ff != '0))
      else $error("eviction notice outside an eviction run");

endmodule
